[rtl/msps_pkg.sv]
// ----------------------------------------------------------------------------
// msps_pkg
// Shared types and constants for the multichannel servo pulse sequencer.
// ----------------------------------------------------------------------------
package msps_pkg;

  localparam int Channels   = 16;   // servo outputs
  localparam int ChW        = 4;    // width of a channel index
  localparam int CountBits  = 16;   // frame counter width
  localparam int UsW        = 15;   // microsecond values and limits
  localparam int TicksW     = 16;   // stored pulse width in ticks
  localparam int TrimW      = 8;
  localparam int ShiftW     = 2;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 16;

  localparam logic [TicksW-1:0] DefWidth = TicksW'(3000);  // 1500 us at reset
  localparam int GapMin     = 4;     // shortest frame gap after the last pulse

  // Angle mapping: p / 180 is done as (p / 4) / 45 with a reciprocal multiply.
  localparam int DegRange   = 180;
  localparam int DegDiv     = DegRange / 4;
  localparam int ProdW      = 2 * UsW;        // value times span
  localparam int RedW       = ProdW - 2;      // product after the divide by 4
  localparam int RecipShift = 34;
  localparam longint unsigned RecipMul = (64'd1 << RecipShift) / DegDiv;
  localparam int RecipW     = 29;
  localparam int QuotW      = RedW + RecipW - RecipShift;
  localparam int UsSumW     = QuotW + 1;

  typedef enum logic [1:0] {
    MODE_TICK       = 2'd0,
    MODE_SET_US     = 2'd1,
    MODE_SET_ANGLE  = 2'd2,
    MODE_SET_ENABLE = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_US     = 3'd0,
    CFG_MAX_US     = 3'd1,
    CFG_ANGLE_LIM  = 3'd2,
    CFG_TRIM       = 3'd3,
    CFG_REFRESH    = 3'd4,
    CFG_TICK_SHIFT = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [UsW-1:0]    min_us;
    logic [UsW-1:0]    max_us;
    logic [UsW-1:0]    angle_lim;
    logic [TrimW-1:0]  trim;
    logic [15:0]       refresh;
    logic [ShiftW-1:0] shift;
  } cfg_t;

  // Write into the width table.
  typedef struct packed {
    logic              en;
    logic [ChW-1:0]    addr;
    logic [TicksW-1:0] data;
  } wr_t;

  // One result word, first field in the highest bits.
  typedef struct packed {
    logic             frame_start;
    logic             in_pulse;
    logic [ChW-1:0]   pulsing_ch;
    logic [15:0]      pin_levels;
  } res_t;

endpackage

[rtl/multichannel_servo_pulse_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// multichannel_servo_pulse_sequencer_unit
// Servo pulse sequencer with a width table in RAM and a two-word output buffer.
// ----------------------------------------------------------------------------
// The result word of an item is registered into the output buffer when the item
// is taken. Throughput: one word per cycle while the buffer has room. A tick that
// follows a width write waits until the three-stage conversion pipeline has
// written the width table; the two-word output buffer keeps input flowing while
// the output stalls for one word. Reset is asynchronous and clears all control
// state; unwritten table entries read as 3000 ticks, so no clearing pass is run.
module multichannel_servo_pulse_sequencer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // channel[3:0], value[18:4], enable_flag[19]
  input  logic [1:0]  s_axis_tuser_i,   // mode[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // pin_levels[15:0], pulsing_channel[19:16],
                                        // in_pulse[20], frame_start[21]
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);
  import msps_pkg::*;

  cfg_t            cfg_q;
  mode_e           mode;
  logic [ChW-1:0]  ch;
  logic [UsW-1:0]  value;
  logic            enable_flag;
  logic            accept;
  logic            wr_busy;
  wr_t             wr;
  logic            rd_en;
  logic [ChW-1:0]  rd_addr;
  logic [TicksW-1:0] rd_data;
  res_t            res;
  res_t            out_q, skid_q;
  logic [1:0]      cnt_q;
  logic            pop;

  assign mode        = mode_e'(s_axis_tuser_i);
  assign ch          = s_axis_tdata_i[3:0];
  assign value       = s_axis_tdata_i[18:4];
  assign enable_flag = s_axis_tdata_i[19];

  // Ticks hold off while a width write is still in flight.
  assign s_axis_tready_o = (cnt_q != 2'd2) && !((mode == MODE_TICK) && wr_busy);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_us    <= UsW'(544);
      cfg_q.max_us    <= UsW'(2400);
      cfg_q.angle_lim <= UsW'(544);
      cfg_q.trim      <= '0;
      cfg_q.refresh   <= 16'd40000;
      cfg_q.shift     <= ShiftW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_US:     cfg_q.min_us    <= cfg_wdata_i[UsW-1:0];
        CFG_MAX_US:     cfg_q.max_us    <= cfg_wdata_i[UsW-1:0];
        CFG_ANGLE_LIM:  cfg_q.angle_lim <= cfg_wdata_i[UsW-1:0];
        CFG_TRIM:       cfg_q.trim      <= cfg_wdata_i[TrimW-1:0];
        CFG_REFRESH:    cfg_q.refresh   <= cfg_wdata_i;
        CFG_TICK_SHIFT: cfg_q.shift     <= cfg_wdata_i[ShiftW-1:0];
        default: ;
      endcase
    end
  end

  msps_width u_width (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (accept && ((mode == MODE_SET_US) || (mode == MODE_SET_ANGLE))),
    .is_angle_i (mode == MODE_SET_ANGLE),
    .ch_i       (ch),
    .value_i    (value),
    .cfg_i      (cfg_q),
    .wr_o       (wr),
    .busy_o     (wr_busy)
  );

  msps_ram #(
    .Width (TicksW),
    .Depth (Channels)
  ) u_width_ram (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  msps_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (accept),
    .mode_i    (mode),
    .ch_i      (ch),
    .enable_i  (enable_flag),
    .cfg_i     (cfg_q),
    .wr_i      (wr),
    .rd_data_i (rd_data),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .res_o     (res)
  );

  // Two-word output buffer: out_q is the head, skid_q the second word.
  assign pop = (cnt_q != 2'd0) && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_q + 2'(accept) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop)) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
    if (pop && (cnt_q == 2'd2)) begin
      out_q <= skid_q;
    end
  end

  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = {2'b00, out_q};

endmodule

[rtl/msps_ram.sv]
// ----------------------------------------------------------------------------
// msps_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module msps_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/msps_width.sv]
// ----------------------------------------------------------------------------
// msps_width
// Width conversion pipeline: angle mapping, clamping and scaling to ticks,
// ending in a write to the width table from the last stage.
// ----------------------------------------------------------------------------
module msps_width (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic                    is_angle_i,
  input  logic [msps_pkg::ChW-1:0] ch_i,
  input  logic [msps_pkg::UsW-1:0] value_i,
  input  msps_pkg::cfg_t          cfg_i,
  output msps_pkg::wr_t           wr_o,
  output logic                    busy_o
);
  import msps_pkg::*;

  // Stage 1: product of the angle and the span.
  logic              s1_valid_q, s1_map_q;
  logic [ChW-1:0]    s1_ch_q;
  logic [UsW-1:0]    s1_value_q;
  logic [ProdW-1:0]  s1_prod_q;
  // Stage 2: reciprocal estimate of the quotient.
  logic              s2_valid_q, s2_map_q;
  logic [ChW-1:0]    s2_ch_q;
  logic [UsW-1:0]    s2_value_q;
  logic [RedW-1:0]   s2_red_q;
  logic [QuotW-1:0]  s2_quot_q;
  // Stage 3: corrected quotient.
  logic              s3_valid_q, s3_map_q;
  logic [ChW-1:0]    s3_ch_q;
  logic [UsW-1:0]    s3_value_q;
  logic [QuotW-1:0]  s3_quot_q;

  logic [UsW-1:0]          span;
  logic                    map;
  logic [ProdW-1:0]        prod;
  logic [RedW-1:0]         red;
  logic [RedW+RecipW-1:0]  recip_prod;
  logic [RedW-1:0]         back_mul;
  logic [RedW-1:0]         rem;
  logic [QuotW-1:0]        quot;
  logic [UsSumW-1:0]       us;
  logic [UsSumW-1:0]       lo_ext, hi_ext;
  logic [UsW-1:0]          clamped;
  logic [UsW+2:0]          scaled;
  logic [TicksW-1:0]       ticks;

  // An inverted limit pair maps every angle to the minimum, so the span is zero.
  assign span = (cfg_i.max_us >= cfg_i.min_us) ? (cfg_i.max_us - cfg_i.min_us) : '0;
  assign map  = is_angle_i && (value_i < cfg_i.angle_lim);
  assign prod = ProdW'(value_i) * ProdW'(span);

  assign red        = s1_prod_q[ProdW-1:2];
  assign recip_prod = (RedW+RecipW)'(red) * (RedW+RecipW)'(RecipMul);

  // The estimate is the true quotient or one below it.
  assign back_mul = RedW'(s2_quot_q) * RedW'(DegDiv);
  assign rem      = s2_red_q - back_mul;
  assign quot     = (rem >= RedW'(DegDiv)) ? (s2_quot_q + QuotW'(1)) : s2_quot_q;

  always_comb begin
    lo_ext = UsSumW'(cfg_i.min_us);
    hi_ext = UsSumW'(cfg_i.max_us);
    us     = s3_map_q ? (lo_ext + UsSumW'(s3_quot_q)) : UsSumW'(s3_value_q);
    if (us <= lo_ext) begin
      clamped = cfg_i.min_us;
    end else if (us >= hi_ext) begin
      clamped = cfg_i.max_us;
    end else begin
      clamped = us[UsW-1:0];
    end
    scaled = (UsW+3)'(clamped) << cfg_i.shift;
    ticks  = (scaled > (UsW+3)'(16'hFFFF)) ? 16'hFFFF : scaled[TicksW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_map_q   <= map;
    s1_ch_q    <= ch_i;
    s1_value_q <= value_i;
    s1_prod_q  <= prod;
    s2_map_q   <= s1_map_q;
    s2_ch_q    <= s1_ch_q;
    s2_value_q <= s1_value_q;
    s2_red_q   <= red;
    s2_quot_q  <= recip_prod[RedW+RecipW-1:RecipShift];
    s3_map_q   <= s2_map_q;
    s3_ch_q    <= s2_ch_q;
    s3_value_q <= s2_value_q;
    s3_quot_q  <= quot;
  end

  assign wr_o.en   = s3_valid_q;
  assign wr_o.addr = s3_ch_q;
  assign wr_o.data = ticks;
  assign busy_o    = s1_valid_q | s2_valid_q | s3_valid_q;

endmodule

[rtl/msps_seq.sv]
// ----------------------------------------------------------------------------
// msps_seq
// Frame sequencer: frame counter, channel walk, pulse and frame end events.
// The width of a newly started channel is read from the table and the pulse
// end is formed in the next cycle from the read data.
// ----------------------------------------------------------------------------
module msps_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  msps_pkg::mode_e            mode_i,
  input  logic [msps_pkg::ChW-1:0]   ch_i,
  input  logic                       enable_i,
  input  msps_pkg::cfg_t             cfg_i,
  input  msps_pkg::wr_t              wr_i,
  input  logic [msps_pkg::TicksW-1:0] rd_data_i,
  output logic                       rd_en_o,
  output logic [msps_pkg::ChW-1:0]   rd_addr_o,
  output msps_pkg::res_t             res_o
);
  import msps_pkg::*;

  logic [CountBits-1:0] count_q, count_d;
  logic [Channels-1:0]  en_mask_q, en_mask_d;
  logic [ChW-1:0]       active_q, active_d;
  logic                 pulse_q, pulse_d;
  logic [CountBits-1:0] pulse_end_q, pulse_end_d;
  logic [CountBits-1:0] frame_end_q, frame_end_d;
  logic                 pend_q, pend_d;
  logic [CountBits-1:0] start_q, start_d;
  logic [Channels-1:0]  written_q;
  logic                 rd_ok_q;

  logic                 is_tick;
  logic [TicksW-1:0]    width_eff;
  logic [CountBits-1:0] dur;
  logic [CountBits-1:0] end_now;
  logic                 end_hit, gap_hit, do_start;
  logic [ChW:0]         base;
  logic                 found;
  logic [ChW-1:0]       found_idx;
  logic [CountBits-1:0] cnt_base, gap_next, refresh_c;

  assign is_tick = valid_i && (mode_i == MODE_TICK);

  // Pulse end of a channel started in the previous cycle, from the read data.
  always_comb begin
    width_eff = rd_ok_q ? rd_data_i : DefWidth;
    dur       = CountBits'(17'(width_eff) + 17'(cfg_i.trim));
    if (dur == '0) begin
      dur = CountBits'(1);
    end
    end_now = pend_q ? (start_q + dur) : pulse_end_q;
  end

  assign end_hit  = pulse_q && (count_q == end_now);
  assign gap_hit  = !pulse_q && (count_q == frame_end_q);
  assign do_start = is_tick && (end_hit || gap_hit);
  assign base     = gap_hit ? '0 : ((ChW+1)'(active_q) + (ChW+1)'(1));
  assign cnt_base = gap_hit ? '0 : count_q;

  // Lowest enabled channel at or above the base index.
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = Channels - 1; i >= 0; i--) begin
      if (en_mask_q[i] && ((ChW+1)'(i) >= base)) begin
        found     = 1'b1;
        found_idx = ChW'(i);
      end
    end
  end

  always_comb begin
    refresh_c = CountBits'(cfg_i.refresh);
    gap_next  = cnt_base + CountBits'(GapMin);
    if (refresh_c > gap_next) begin
      gap_next = refresh_c;
    end
  end

  always_comb begin
    count_d     = count_q;
    en_mask_d   = en_mask_q;
    active_d    = active_q;
    pulse_d     = pulse_q;
    pulse_end_d = end_now;
    frame_end_d = frame_end_q;
    pend_d      = 1'b0;
    start_d     = start_q;
    if (is_tick) begin
      count_d = cnt_base + CountBits'(1);
    end
    if (do_start) begin
      if (found) begin
        active_d = found_idx;
        pulse_d  = 1'b1;
        pend_d   = 1'b1;
        start_d  = cnt_base;
      end else begin
        pulse_d     = 1'b0;
        frame_end_d = gap_next;
      end
    end
    if (valid_i && (mode_i == MODE_SET_ENABLE) && ((ChW+1)'(ch_i) < (ChW+1)'(Channels))) begin
      en_mask_d[ch_i] = enable_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      en_mask_q   <= '0;
      active_q    <= '0;
      pulse_q     <= 1'b0;
      pulse_end_q <= '0;
      frame_end_q <= '0;
      pend_q      <= 1'b0;
      start_q     <= '0;
      written_q   <= '0;
      rd_ok_q     <= 1'b0;
    end else begin
      count_q     <= count_d;
      en_mask_q   <= en_mask_d;
      active_q    <= active_d;
      pulse_q     <= pulse_d;
      pulse_end_q <= pulse_end_d;
      frame_end_q <= frame_end_d;
      pend_q      <= pend_d;
      start_q     <= start_d;
      if (wr_i.en) begin
        written_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_o) begin
        rd_ok_q <= written_q[found_idx];
      end
    end
  end

  assign rd_en_o   = do_start && found;
  assign rd_addr_o = found_idx;

  always_comb begin
    res_o             = '0;
    res_o.frame_start = is_tick && gap_hit;
    res_o.in_pulse    = pulse_d;
    if (pulse_d) begin
      res_o.pulsing_ch = active_d;
      res_o.pin_levels = 16'h1 << active_d;
    end
  end

endmodule

[rtl/msps_chk.sv]
// ----------------------------------------------------------------------------
// msps_chk
// Port-level checks for the servo pulse sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module msps_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [23:0] s_axis_tdata_i,
  input logic [1:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o,
  input logic        cfg_we_i,
  input logic [2:0]  cfg_idx_i,
  input logic [15:0] cfg_wdata_i
);

  // A word only appears on the output after an input word was taken.
  a_out_needs_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o))
    else $error("output word without a preceding input word");

  // Pin levels, channel index and pulse flag agree in every word.
  a_levels_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tdata_o[20] ? (m_axis_tdata_o[15:0] == (16'h1 << m_axis_tdata_o[19:16]))
                          : (m_axis_tdata_o[19:0] == 20'h0)))
    else $error("pin levels disagree with pulsing channel");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("output valid dropped while stalled");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(m_axis_tdata_o))
    else $error("output data changed while stalled");

endmodule

bind multichannel_servo_pulse_sequencer_unit msps_chk u_msps_chk (.*);

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the servo pulse sequencer. Commands and ticks are
// streamed in with random gaps, output words are drained with random stalls,
// and every output word is compared with a cycle-free model of the frame,
// pulse and width-table logic kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import msps_pkg::*;

  typedef struct {
    mode_e          mode;
    logic [ChW-1:0] ch;
    logic [UsW-1:0] val;
    logic           en;
  } servo_cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_wdata_i = '0;

  multichannel_servo_pulse_sequencer_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Bench-side copy of the sequencer state and its registers.
  logic [UsW-1:0]    lim_min, lim_max, lim_angle;
  logic [TrimW-1:0]  trim_add;
  logic [15:0]       refresh_len;
  logic [ShiftW-1:0] shift_amt;
  logic [15:0]       frame_cnt;
  logic [TicksW-1:0] width_tab [Channels];
  logic [15:0]       en_mask;
  logic [ChW-1:0]    act_ch;
  logic              pulsing;
  logic [15:0]       pulse_stop;
  logic [15:0]       gap_stop;

  servo_cmd_t cmd_q[$];
  res_t       levels_due[$];
  int         words_queued = 0;
  int         words_taken = 0;
  int         mismatches = 0;

  logic in_hs = 1'b0;
  logic out_hs = 1'b0;
  int   in_wait = 0;
  int   out_wait = 0;
  bit   in_idle_on = 1'b1;
  bit   out_idle_on = 1'b1;
  bit   quiet = 1'b0;

  initial begin : model_reset
    int k;
    lim_min     = 15'd544;
    lim_max     = 15'd2400;
    lim_angle   = 15'd544;
    trim_add    = '0;
    refresh_len = 16'd40000;
    shift_amt   = 2'd1;
    frame_cnt   = '0;
    for (k = 0; k < Channels; k++) width_tab[k] = DefWidth;
    en_mask    = '0;
    act_ch     = '0;
    pulsing    = 1'b0;
    pulse_stop = '0;
    gap_stop   = '0;
  end

  function automatic logic [TicksW-1:0] us_to_width(longint us);
    longint lo, hi, c;
    longint unsigned t;
    lo = longint'(lim_min);
    hi = longint'(lim_max);
    c  = (us <= lo) ? lo : ((us >= hi) ? hi : us);
    t  = longint'(unsigned'(c)) << shift_amt;
    return (t > 65535) ? 16'hFFFF : t[15:0];
  endfunction

  // Starts the first enabled channel at or after first, or opens the gap.
  function automatic void start_pulse_from(int first);
    int          i;
    logic        found;
    logic [15:0] dur, soonest;
    found = 1'b0;
    for (i = first; i < Channels && !found; i++) begin
      if (en_mask[i]) begin
        dur = width_tab[i] + 16'(trim_add);
        if (dur == 0) dur = 16'd1;
        act_ch     = ChW'(i);
        pulsing    = 1'b1;
        pulse_stop = frame_cnt + dur;
        found      = 1'b1;
      end
    end
    if (!found) begin
      pulsing  = 1'b0;
      soonest  = frame_cnt + 16'(GapMin);
      gap_stop = (refresh_len > soonest) ? refresh_len : soonest;
    end
  endfunction

  function automatic res_t predict_levels(servo_cmd_t c);
    res_t   r;
    logic   fs;
    longint v, lo, hi;
    fs = 1'b0;
    case (c.mode)
      MODE_TICK: begin
        if (pulsing) begin
          if (frame_cnt == pulse_stop) start_pulse_from(int'(act_ch) + 1);
        end else if (frame_cnt == gap_stop) begin
          frame_cnt = '0;
          fs = 1'b1;
          start_pulse_from(0);
        end
      end
      MODE_SET_US: width_tab[c.ch] = us_to_width(longint'(c.val));
      MODE_SET_ANGLE: begin
        v = longint'(c.val);
        if (v < longint'(lim_angle)) begin
          lo = longint'(lim_min);
          hi = longint'(lim_max);
          // Signed division so inverted limits truncate toward zero.
          v = lo + (v * (hi - lo)) / DegRange;
        end
        width_tab[c.ch] = us_to_width(v);
      end
      default: en_mask[c.ch] = c.en;
    endcase
    r.pin_levels  = pulsing ? (16'd1 << act_ch) : 16'd0;
    r.pulsing_ch  = pulsing ? act_ch : '0;
    r.in_pulse    = pulsing;
    r.frame_start = fs;
    if (c.mode == MODE_TICK) frame_cnt = frame_cnt + 16'd1;
    return r;
  endfunction

  function automatic void apply_reg(cfg_idx_e idx, logic [15:0] data);
    case (idx)
      CFG_MIN_US:     lim_min = data[UsW-1:0];
      CFG_MAX_US:     lim_max = data[UsW-1:0];
      CFG_ANGLE_LIM:  lim_angle = data[UsW-1:0];
      CFG_TRIM:       trim_add = data[TrimW-1:0];
      CFG_REFRESH:    refresh_len = data;
      CFG_TICK_SHIFT: shift_amt = data[ShiftW-1:0];
      default: ;
    endcase
  endfunction

  // Output words are checked before the word taken on the same edge is
  // predicted, since a word never leaves in the cycle it arrives.
  always @(posedge clk_i) begin : check_levels
    res_t       want, got;
    servo_cmd_t c;
    in_hs  <= s_axis_tvalid_i && s_axis_tready_o;
    out_hs <= m_axis_tvalid_o && m_axis_tready_i;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = res_t'(m_axis_tdata_o[$bits(res_t)-1:0]);
        if (levels_due.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual %h", $time, got);
          mismatches++;
        end else begin
          want = levels_due.pop_front();
          if (want !== got) begin
            $display("%0t: mismatch expected pins=%h ch=%0d pulse=%b fs=%b",
                     $time, want.pin_levels, want.pulsing_ch, want.in_pulse,
                     want.frame_start);
            $display("%0t:          actual   pins=%h ch=%0d pulse=%b fs=%b",
                     $time, got.pin_levels, got.pulsing_ch, got.in_pulse,
                     got.frame_start);
            mismatches++;
          end
        end
      end
      if (cfg_we_i) apply_reg(cfg_idx_e'(cfg_idx_i), cfg_wdata_i);
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        c.mode = mode_e'(s_axis_tuser_i);
        c.ch   = s_axis_tdata_i[3:0];
        c.val  = s_axis_tdata_i[18:4];
        c.en   = s_axis_tdata_i[19];
        levels_due.push_back(predict_levels(c));
        words_taken++;
      end
    end
  end

  always @(negedge clk_i) begin : drive_cmds
    logic       nv;
    servo_cmd_t c;
    if (rst_ni) begin
      nv = s_axis_tvalid_i && !in_hs;
      if (!nv) begin
        if (in_wait > 0) begin
          in_wait--;
        end else if (cmd_q.size() > 0) begin
          c = cmd_q.pop_front();
          s_axis_tdata_i <= {4'b0, c.en, c.val, c.ch};
          s_axis_tuser_i <= c.mode;
          nv = 1'b1;
          if ($urandom_range(0, 31) == 0) in_idle_on = !in_idle_on;
          in_wait = (in_idle_on && !quiet) ? $urandom_range(0, 8) : 0;
        end
      end
      s_axis_tvalid_i <= nv;
    end
  end

  always @(negedge clk_i) begin : drain_levels
    if (rst_ni) begin
      if (out_hs) begin
        if ($urandom_range(0, 31) == 0) out_idle_on = !out_idle_on;
        out_wait = (out_idle_on && !quiet) ? $urandom_range(0, 8) : 0;
      end else if (out_wait > 0) begin
        out_wait--;
      end
      m_axis_tready_i <= (out_wait == 0);
    end
  end

  task automatic queue_word(mode_e m, int ch, int val, bit en);
    servo_cmd_t c;
    c.mode = m;
    c.ch   = ch[ChW-1:0];
    c.val  = val[UsW-1:0];
    c.en   = en;
    cmd_q.push_back(c);
    words_queued++;
  endtask

  task automatic queue_random();
    int    r, val;
    mode_e m;
    r = $urandom_range(0, 99);
    if (r < 68)      m = MODE_TICK;
    else if (r < 78) m = MODE_SET_US;
    else if (r < 86) m = MODE_SET_ANGLE;
    else             m = MODE_SET_ENABLE;
    case ($urandom_range(0, 2))
      0:       val = $urandom_range(0, 40);
      1:       val = $urandom_range(0, 200);
      default: val = $urandom_range(0, 32767);
    endcase
    queue_word(m, $urandom_range(0, Channels - 1), val, 1'($urandom_range(0, 1)));
  endtask

  // Waits until every word is in and out, then lets the width pipeline drain.
  task automatic settle();
    while (words_taken != words_queued || levels_due.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic program_regs(int mn, int mx, int al, int tr, int rf, int sh);
    cfg_idx_e regs [6];
    int       vals [6];
    int       k;
    regs = '{CFG_MIN_US, CFG_MAX_US, CFG_ANGLE_LIM, CFG_TRIM, CFG_REFRESH, CFG_TICK_SHIFT};
    vals = '{mn, mx, al, tr, rf, sh};
    for (k = 0; k < 6; k++) begin
      @(negedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= regs[k];
      cfg_wdata_i <= 16'(vals[k]);
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Fresh widths on every channel first, so no channel keeps a long default.
  task automatic run_phase(int n);
    int k;
    for (k = 0; k < Channels; k++) queue_word(MODE_SET_US, k, $urandom_range(0, 40), 1'b0);
    for (k = 0; k < n; k++) queue_random();
    settle();
  endtask

  initial begin : stimulus
    int k;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Conversions under the reset limits; an angle past the limit is microseconds.
    queue_word(MODE_SET_US, 14, 1000, 1'b0);
    queue_word(MODE_SET_ANGLE, 15, 90, 1'b0);
    queue_word(MODE_SET_ANGLE, 13, 600, 1'b0);
    settle();

    // Saturated width that wraps with the trim to zero, a zero width, and
    // a frame that ends on the short gap because refresh is zero.
    program_regs(0, 32767, 0, 1, 0, 3);
    queue_word(MODE_SET_US, 0, 32767, 1'b0);
    queue_word(MODE_SET_US, 1, 0, 1'b0);
    queue_word(MODE_SET_ANGLE, 2, 0, 1'b0);
    for (k = 0; k < 3; k++) queue_word(MODE_SET_ENABLE, k, 0, 1'b1);
    for (k = 0; k < 8; k++) queue_word(MODE_TICK, 0, 0, 1'b0);
    settle();

    // Angle end points, the angle limit itself, and a disable mid-frame.
    program_regs(3, 20, 181, 0, 30, 0);
    queue_word(MODE_SET_ANGLE, 0, 180, 1'b0);
    queue_word(MODE_SET_ANGLE, 1, 0, 1'b0);
    queue_word(MODE_SET_ANGLE, 2, 181, 1'b0);
    queue_word(MODE_SET_ENABLE, 1, 32767, 1'b0);
    for (k = 0; k < 4; k++) queue_word(MODE_TICK, 15, 32767, 1'b1);
    settle();

    program_regs(2, 12, 181, 0, 0, 0);
    run_phase(120);
    program_regs(1, 12, 100, 3, 120, 1);
    run_phase(120);
    // Inverted limits.
    program_regs(10, 3, 181, 0, 40, 2);
    run_phase(120);
    program_regs(0, 6, 32767, 255, 300, 3);
    run_phase(120);
    program_regs(32767, 32767, 0, 1, 10, 3);
    run_phase(120);

    // Back-to-back ticks with no idling on either side.
    quiet = 1'b1;
    program_regs(1, 4, 181, 0, 40, 0);
    for (k = 0; k < 4; k++) queue_word(MODE_SET_ENABLE, k, 0, 1'b1);
    for (k = 0; k < 40; k++)
      queue_word(MODE_TICK, $urandom_range(0, 15), $urandom_range(0, 32767),
                 1'($urandom_range(0, 1)));
    settle();

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
